[design/hcbp_pkg.sv]
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the code table bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int NUM_SYMBOLS_DEF  = 256;

    localparam int BYTE_BITS = 8;
    localparam int CODE_W    = 32;
    localparam int PEND_W    = BYTE_BITS - 1;
    localparam int PCNT_W    = 3;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

    // Item handed from the accept logic to the packing stage
    typedef struct packed {
        logic valid;
        logic flush;
    } issue_t;

endpackage

[design/huffman_code_bit_packer.sv]
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Code table plus MSB-first bit packer: loads, encodes and flushes byte
// symbols into a stream of packed bytes.
// ----------------------------------------------------------------------------
//  channel | direction | words
//  s_      | in        | op, symbol, code_bits, code_length
//  m_      | out       | out_byte, last (set on the final word of an item)
//
//  Takes one item per cycle while each item yields at most one word and
//  m_ready is high; an item that yields more words holds s_ready low until
//  its last word is loaded, as the output register drains one word a cycle.
//  A word passes the table read register, then the output register.
//  The table RAM is written at the accept edge of a load, so an encode in the
//  next cycle already reads the new entry.
//  Reset clears the waiting bits and the pipeline; the table is not cleared and
//  is undefined until loaded. A held word (m_ready low) stalls items with words.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int NUM_SYMBOLS  = hcbp_pkg::NUM_SYMBOLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_op,
    input  logic [7:0]                      s_symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]     s_code_bits,
    input  logic [5:0]                      s_code_length,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [hcbp_pkg::BYTE_BITS-1:0]  m_out_byte,
    output logic                            m_last
);

    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
    localparam int IDX_W = $clog2(NUM_SYMBOLS);
    localparam int ENT_W = hcbp_pkg::CODE_W + LEN_W;

    logic              accept;
    logic              sym_ok;
    logic              do_load, do_encode, do_flush;
    logic [LEN_W-1:0]  len_sat;
    logic [ENT_W-1:0]  rd_entry;
    hcbp_pkg::issue_t  issue;

    assign accept = s_valid && s_ready;
    assign sym_ok = {1'b0, s_symbol} < 9'(NUM_SYMBOLS);

    // decode the op; out-of-table symbols and the unused op are dropped here
    assign do_load   = accept && (s_op == hcbp_pkg::OP_LOAD)   && sym_ok;
    assign do_encode = accept && (s_op == hcbp_pkg::OP_ENCODE) && sym_ok;
    assign do_flush  = accept && (s_op == hcbp_pkg::OP_FLUSH);

    // saturate long lengths to the table's limit
    assign len_sat = (s_code_length > 6'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                        : LEN_W'(s_code_length);

    hcbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_table (
        .aclk  (aclk),
        .we    (do_load),
        .waddr (s_symbol[IDX_W-1:0]),
        .wdata ({s_code_bits, len_sat}),
        .re    (do_encode),
        .raddr (s_symbol[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    // the packer picks up the item together with the read data
    assign issue.valid = do_encode || do_flush;
    assign issue.flush = do_flush;

    hcbp_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_packer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .issue      (issue),
        .entry_code (rd_entry[ENT_W-1:LEN_W]),
        .entry_len  (rd_entry[LEN_W-1:0]),
        .free       (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule

[design/hcbp_ram.sv]
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/hcbp_packer.sv]
// ----------------------------------------------------------------------------
// hcbp_packer
// Bit accumulator and byte emitter: appends a looked-up code to the waiting
// bits and sends full bytes, one per cycle unless stalled, via an output reg.
// ----------------------------------------------------------------------------
module hcbp_packer #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  hcbp_pkg::issue_t                     issue,
    input  logic [hcbp_pkg::CODE_W-1:0]          entry_code,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0]    entry_len,
    output logic                                 free,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [hcbp_pkg::BYTE_BITS-1:0]       m_out_byte,
    output logic                                 m_last
);

    localparam int ACC_W     = MAX_CODE_LEN + hcbp_pkg::PEND_W;
    localparam int TOT_W     = $clog2(ACC_W + 1);
    localparam int THR_W     = $clog2(ACC_W + hcbp_pkg::BYTE_BITS + 1);
    localparam int MAX_BYTES = ACC_W / hcbp_pkg::BYTE_BITS;
    localparam int K_W       = $clog2(MAX_BYTES + 1);

    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_flush_reg, s1_flush_next;
    logic [K_W-1:0]                k_reg, k_next;
    logic [hcbp_pkg::PEND_W-1:0]   pend_bits_reg, pend_bits_next;
    logic [hcbp_pkg::PCNT_W-1:0]   pend_cnt_reg, pend_cnt_next;
    logic                          m_valid_reg, m_valid_next;
    logic [hcbp_pkg::BYTE_BITS-1:0] m_byte_reg, m_byte_next;
    logic                          m_last_reg, m_last_next;

    logic [hcbp_pkg::CODE_W-1:0]   code_m;
    logic [ACC_W-1:0]              acc;
    logic [TOT_W-1:0]              total;
    logic [THR_W-1:0]              thr;
    logic [TOT_W-1:0]              shift;
    logic                          enc_has, enc_last, fl_has;
    logic [hcbp_pkg::BYTE_BITS-1:0] enc_byte, fl_byte;
    logic                          has_byte, is_last, out_load, emit, done;
    logic [hcbp_pkg::BYTE_BITS-1:0] cur_byte;
    logic [hcbp_pkg::PCNT_W-1:0]   rem;

    // append the masked code to the waiting bits
    assign code_m  = entry_code & ~({hcbp_pkg::CODE_W{1'b1}} << entry_len);
    assign acc     = (ACC_W'(pend_bits_reg) << entry_len) | ACC_W'(code_m);
    assign total   = TOT_W'(pend_cnt_reg) + TOT_W'(entry_len);

    // threshold for the byte about to go out: 8 * (k + 1)
    assign thr      = THR_W'({k_reg, 3'b000}) + THR_W'(hcbp_pkg::BYTE_BITS);
    assign enc_has  = THR_W'(total) >= thr;
    assign enc_last = THR_W'(total) < (thr + THR_W'(hcbp_pkg::BYTE_BITS));
    assign shift    = TOT_W'(THR_W'(total) - thr);
    assign enc_byte = hcbp_pkg::BYTE_BITS'(acc >> shift);
    assign rem      = total[hcbp_pkg::PCNT_W-1:0];

    // partial byte, padded with zeros in the low bits
    assign fl_has  = pend_cnt_reg != '0;
    assign fl_byte = {pend_bits_reg, 1'b0} << (3'd7 - pend_cnt_reg);

    assign has_byte = s1_flush_reg ? fl_has : enc_has;
    assign is_last  = s1_flush_reg ? 1'b1 : enc_last;
    assign cur_byte = s1_flush_reg ? fl_byte : enc_byte;

    assign out_load = !m_valid_reg || m_ready;
    assign emit     = s1_valid_reg && has_byte && out_load;
    assign done     = s1_valid_reg && (!has_byte || (is_last && out_load));
    assign free     = !s1_valid_reg || done;

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        s1_flush_next  = s1_flush_reg;
        k_next         = k_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;

        if (emit && !is_last) begin
            k_next = k_reg + K_W'(1);
        end
        if (done) begin
            k_next = '0;
            if (s1_flush_reg) begin
                pend_bits_next = '0;
                pend_cnt_next  = '0;
            end else begin
                pend_bits_next = acc[hcbp_pkg::PEND_W-1:0]
                               & ~({hcbp_pkg::PEND_W{1'b1}} << rem);
                pend_cnt_next  = rem;
            end
        end
        if (free) begin
            s1_valid_next = issue.valid;
            s1_flush_next = issue.flush;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        if (out_load) begin
            m_valid_next = emit;
            m_byte_next  = cur_byte;
            m_last_next  = is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s1_flush_reg  <= 1'b0;
            k_reg         <= '0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            s1_flush_reg  <= s1_flush_next;
            k_reg         <= k_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;

endmodule

[design/hcbp_checker.sv]
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks of the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module hcbp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [1:0]                      s_op,
    input logic [7:0]                      s_symbol,
    input logic [hcbp_pkg::CODE_W-1:0]     s_code_bits,
    input logic [5:0]                      s_code_length,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [hcbp_pkg::BYTE_BITS-1:0]  m_out_byte,
    input logic                            m_last
);

    // an offered input word holds until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid
            && $stable({s_op, s_symbol, s_code_bits, s_code_length}))
        else $error("offered input word changed before acceptance");

    // a stalled word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last))
        else $error("stalled output word changed");

    // no word straight out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // words of one item follow each other without a gap
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("gap inside a multi-word item");

    // input held back only while a word is on its way out
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> m_valid)
        else $error("input stalled with no output pending");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);
